FILE: src/fys_pkg.sv
// ----------------------------------------------------------------------------
// fys_pkg: shared types and constants for the shuffle engine
// field widths of the item ports and the divider control bundle
// ----------------------------------------------------------------------------
`default_nettype none

package fys_pkg;

  // fixed field widths of the ports
  localparam int unsigned WORD_W  = 31;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned VALUE_W = 11;

  // bit counter of the serial divider, holds 0..WORD_W
  localparam int unsigned STEP_W = $clog2(WORD_W + 1);

  // count register value after reset
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

  // control from the sequencer to the serial divider
  typedef struct packed {
    logic load;  // take a new random word, clear the remainder
    logic run;   // shift one bit of the word into the remainder
  } div_ctrl_t;

endpackage

`default_nettype wire

FILE: src/fys_ram.sv
// ----------------------------------------------------------------------------
// fys_ram: permutation table storage
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fys_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 11
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/fys_div.sv
// ----------------------------------------------------------------------------
// fys_div: bit-serial remainder unit
// restoring modulo of the random word by a narrow divisor, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module fys_div
  import fys_pkg::*;
#(
  parameter int unsigned REM_W = 11
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire div_ctrl_t         ctrl_i,
  input  wire logic [WORD_W-1:0] word_i,
  input  wire logic [REM_W-1:0]  divisor_i,
  output      logic              done_o,
  output      logic [REM_W-1:0]  rem_o
);

  logic [WORD_W-1:0] word_q, word_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;

  assign done_o = (step_q == STEP_W'(WORD_W));
  assign rem_o  = rem_q;

  // shift in the next bit msb first, subtract the divisor when it fits
  assign trial = {rem_q, word_q[WORD_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    word_d = word_q;
    rem_d  = rem_q;
    step_d = step_q;
    if (ctrl_i.load) begin
      word_d = word_i;
      rem_d  = '0;
      step_d = '0;
    end else if (ctrl_i.run && !done_o) begin
      word_d = {word_q[WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[REM_W-1:0];
      end else begin
        rem_d = trial[REM_W-1:0];
      end
      step_d = step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    rem_q  <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_W'(WORD_W);
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/fisher_yates_shuffle_engine.sv
// after accept the result item is offered once the bit-serial remainder unit has shifted
//   in every bit of the word and signalled done, then two reads, two writes, the emit
// the first item of a run first fills the table with 1..count
// the closing step adds a read of entry 0 and its extra item
// words are taken one at a time, not during a step; a full output register stalls the step
// reset: asynchronous active low, count returns to 1024 and no run is active
// ----------------------------------------------------------------------------
// fisher_yates_shuffle_engine: backward fisher-yates permutation generator
// one random word per item settles one position of the permutation
// ----------------------------------------------------------------------------
`default_nettype none

module fisher_yates_shuffle_engine
  import fys_pkg::*;
#(
  parameter int unsigned MAX_COUNT = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration: element count
  input  wire logic               cfg_we_i,
  input  wire logic [COUNT_W-1:0] cfg_wdata_i,
  // random word items
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [WORD_W-1:0]  random_word_i,
  // permutation items
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [POS_W-1:0]   position_o,
  output      logic [VALUE_W-1:0] value_o,
  output      logic               last_o
);

  // table index and table value widths follow the maximum count
  localparam int unsigned IDX_W = $clog2(MAX_COUNT);
  localparam int unsigned VAL_W = $clog2(MAX_COUNT + 1);
  // width that holds both the count register and MAX_COUNT
  localparam int unsigned CNT_W = (VAL_W > COUNT_W) ? VAL_W : COUNT_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,  // wait for a random word
    S_ONE   = 11'b000_0000_0010,  // count of one, emit the single entry
    S_INIT  = 11'b000_0000_0100,  // fill entries 0..n-1 with 1..n
    S_DIV   = 11'b000_0000_1000,  // serial remainder r = word mod (i+1)
    S_RD_R  = 11'b000_0001_0000,  // read entry r
    S_RD_I  = 11'b000_0010_0000,  // read entry i, capture entry r
    S_WR_R  = 11'b000_0100_0000,  // entry r takes old entry i
    S_WR_I  = 11'b000_1000_0000,  // entry i takes old entry r
    S_EMIT  = 11'b001_0000_0000,  // emit the settled entry i
    S_RD_0  = 11'b010_0000_0000,  // closing step, read entry 0
    S_LAST  = 11'b100_0000_0000   // emit entry 0 as the last item
  } state_e;

  state_e state_q, state_d;

  // configuration and run state
  logic [COUNT_W-1:0] count_q, count_d;
  logic               run_q, run_d;
  logic [IDX_W-1:0]   pos_q, pos_d;      // current position i
  logic [IDX_W-1:0]   init_q, init_d;    // table fill pointer
  logic [IDX_W-1:0]   r_q, r_d;          // swap partner
  logic [VAL_W-1:0]   a_q, a_d;          // old entry r

  // output register
  logic               out_valid_q, out_valid_d;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  logic [VALUE_W-1:0] out_value_q, out_value_d;
  logic               out_last_q, out_last_d;
  logic               out_free;
  logic               out_load;

  // divider hookup
  div_ctrl_t          div_ctrl;
  logic               div_done;
  logic [VAL_W-1:0]   div_rem;
  logic [VAL_W-1:0]   divisor;

  // table hookup
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [VAL_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [VAL_W-1:0]   ram_rdata;

  // clamped element count of a new run
  logic [CNT_W-1:0]   count_ext;
  logic [CNT_W-1:0]   n_clamped;

  logic               in_accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // the output register frees up in the same cycle its item is taken
  assign out_free = !out_valid_q || !out_stall_i;

  assign count_ext = CNT_W'(count_q);
  always_comb begin
    n_clamped = count_ext;
    if (count_ext == '0) begin
      n_clamped = CNT_W'(1);
    end else if (count_ext > CNT_W'(MAX_COUNT)) begin
      n_clamped = CNT_W'(MAX_COUNT);
    end
  end

  assign divisor = VAL_W'(pos_q) + VAL_W'(1);

  // configuration register: the user must write it only while idle, the block does not enforce this
  assign count_d = cfg_we_i ? cfg_wdata_i : count_q;

  // step sequencer
  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    pos_d       = pos_q;
    init_d      = init_q;
    r_d         = r_q;
    a_d         = a_q;
    div_ctrl    = '0;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = a_q;
    ram_re      = 1'b0;
    ram_raddr   = pos_q;
    out_load    = 1'b0;
    out_pos_d   = out_pos_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          div_ctrl.load = 1'b1;
          if (run_q) begin
            state_d = S_DIV;
          end else if (n_clamped == CNT_W'(1)) begin
            // single element, the word is not needed
            state_d = S_ONE;
          end else begin
            // new run: latch n-1 as the first position, refill the table
            pos_d   = IDX_W'(n_clamped - CNT_W'(1));
            init_d  = '0;
            run_d   = 1'b1;
            state_d = S_INIT;
          end
        end
      end
      S_ONE: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_pos_d   = '0;
          out_value_d = VALUE_W'(1);
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_q;
        ram_wdata = VAL_W'(init_q) + VAL_W'(1);
        init_d    = init_q + IDX_W'(1);
        if (init_q == pos_q) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        div_ctrl.run = 1'b1;
        if (div_done) begin
          r_d     = IDX_W'(div_rem);
          state_d = S_RD_R;
        end
      end
      S_RD_R: begin
        ram_re    = 1'b1;
        ram_raddr = r_q;
        state_d   = S_RD_I;
      end
      S_RD_I: begin
        ram_re    = 1'b1;
        ram_raddr = pos_q;
        a_d       = ram_rdata;
        state_d   = S_WR_R;
      end
      S_WR_R: begin
        // read data now holds old entry i
        ram_we    = 1'b1;
        ram_waddr = r_q;
        ram_wdata = ram_rdata;
        state_d   = S_WR_I;
      end
      S_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = a_q;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_pos_d   = POS_W'(pos_q);
          out_value_d = VALUE_W'(a_q);
          out_last_d  = 1'b0;
          if (pos_q == IDX_W'(1)) begin
            state_d = S_RD_0;
          end else begin
            pos_d   = pos_q - IDX_W'(1);
            state_d = S_IDLE;
          end
        end
      end
      S_RD_0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = S_LAST;
      end
      S_LAST: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_pos_d   = '0;
          out_value_d = VALUE_W'(ram_rdata);
          out_last_d  = 1'b1;
          run_d       = 1'b0;
          pos_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid: set on load, cleared when the item is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= COUNT_RESET;
      run_q       <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      run_q       <= run_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    init_q      <= init_d;
    r_q         <= r_d;
    a_q         <= a_d;
    out_pos_q   <= out_pos_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  fys_div #(
    .REM_W(VAL_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (div_ctrl),
    .word_i   (random_word_i),
    .divisor_i(divisor),
    .done_o   (div_done),
    .rem_o    (div_rem)
  );

  fys_ram #(
    .DEPTH (MAX_COUNT),
    .ADDR_W(IDX_W),
    .DATA_W(VAL_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign position_o  = out_pos_q;
  assign value_o     = out_value_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

FILE: src/fys_checker.sv
// ----------------------------------------------------------------------------
// fys_checker: port-level checks of the shuffle engine
// watches the handshakes and the closing item of a permutation
// ----------------------------------------------------------------------------
`default_nettype none

module fys_checker
  import fys_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [POS_W-1:0]   position_o,
  input wire logic [VALUE_W-1:0] value_o,
  input wire logic               last_o
);

  // a stalled item stays offered
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // a stalled item keeps its payload
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(position_o) && $stable(value_o) && $stable(last_o))
    else $error("output payload changed while stalled");

  // the closing item always settles position 0
  a_last_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> position_o == '0)
    else $error("last item not at position 0");

  // an accepted word keeps the engine busy in the next cycle
  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted back to back");

endmodule

bind fisher_yates_shuffle_engine fys_checker u_fys_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .position_o (position_o),
  .value_o    (value_o),
  .last_o     (last_o)
);

`default_nettype wire

FILE: tb/fys_perm_checker.sv
// ----------------------------------------------------------------------------
// fys_perm_checker: scoreboard for the shuffle engine
// mirrors the count register, predicts the settled entries of each
// accepted random word and compares them with the output items in order
// ----------------------------------------------------------------------------
module fys_perm_checker
  import fys_pkg::*;
#(
  parameter int unsigned MAX_COUNT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [WORD_W-1:0]  random_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic               last_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    logic               last;
  } settled_entry_t;

  settled_entry_t     settled_q[$];
  settled_entry_t     want;
  logic [COUNT_W-1:0] count_q;
  logic [VALUE_W-1:0] slot_value [MAX_COUNT];
  bit                 slot_written [MAX_COUNT];
  int unsigned        next_pos;
  bit                 run_open;

  // unwritten slots hold their position plus one
  function automatic logic [VALUE_W-1:0] slot_read(input int unsigned p);
    return slot_written[p] ? slot_value[p] : VALUE_W'(p + 1);
  endfunction

  task automatic slot_store(input int unsigned p, input logic [VALUE_W-1:0] v);
    slot_value[p]   = v;
    slot_written[p] = 1'b1;
  endtask

  task automatic push_entry(input int unsigned p, input logic [VALUE_W-1:0] v,
                            input logic lst);
    settled_entry_t e;
    e.position = POS_W'(p);
    e.value    = v;
    e.last     = lst;
    settled_q.push_back(e);
  endtask

  // one backward swap step, starting a new run when none is open
  task automatic settle_step(input logic [WORD_W-1:0] word);
    int unsigned        n;
    int unsigned        i;
    int unsigned        r;
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    bit                 single;
    single = 1'b0;
    if (!run_open) begin
      n = count_q;
      if (n == 0) n = 1;
      if (n > MAX_COUNT) n = MAX_COUNT;
      foreach (slot_written[k]) slot_written[k] = 1'b0;
      if (n == 1) begin
        push_entry(0, VALUE_W'(1), 1'b1);
        single = 1'b1;
      end else begin
        next_pos = n - 1;
        run_open = 1'b1;
      end
    end
    if (!single) begin
      i = next_pos;
      r = int'(word) % (i + 1);
      a = slot_read(r);
      b = slot_read(i);
      slot_store(r, b);
      slot_store(i, a);
      push_entry(i, a, 1'b0);
      if (i <= 1) begin
        push_entry(0, slot_read(0), 1'b1);
        run_open = 1'b0;
        next_pos = 0;
      end else begin
        next_pos = i - 1;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  = COUNT_RESET;
      run_open = 1'b0;
      next_pos = 0;
      foreach (slot_written[k]) slot_written[k] = 1'b0;
      settled_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (settled_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected item, expected none, got pos %0d value %0d last %0b",
                   $time, position_i, value_i, last_i);
        end else begin
          want = settled_q.pop_front();
          if (position_i !== want.position) begin
            errors_o++;
            $display("%0t: position expected %0d got %0d", $time, want.position, position_i);
          end
          if (value_i !== want.value) begin
            errors_o++;
            $display("%0t: value at %0d expected %0d got %0d", $time, want.position,
                     want.value, value_i);
          end
          if (last_i !== want.last) begin
            errors_o++;
            $display("%0t: last at %0d expected %0b got %0b", $time, want.position,
                     want.last, last_i);
          end
        end
      end
      if (cfg_we_i) count_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) settle_step(random_word_i);
      pending_o = settled_q.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: shuffle engine stimulus and verdict
// directed corner runs, then random runs of mostly small sizes under several
// idling mixes, an output hold-off that backs up the input, and finally a
// partial run at the largest size; a checker beside the engine scores every item
// ----------------------------------------------------------------------------
module testbench;
  import fys_pkg::*;

  localparam int unsigned MAX_COUNT = 1024;
  localparam logic [WORD_W-1:0] WORD_ONES = '1;

  // idling mixes for the two channels
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [WORD_W-1:0]  random_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [POS_W-1:0]   position_o;
  logic [VALUE_W-1:0] value_o;
  logic               last_o;

  int errors;
  int pending;

  // idling odds in percent per cycle
  int send_pct = 0;
  int recv_pct = 0;
  // long output hold-off, handed to the stall process which counts it down
  int hold_request = 0;
  int hold_left = 0;

  // stimulus-side view of the run, only to know where run boundaries fall
  logic [COUNT_W-1:0] count_shadow = COUNT_RESET;
  int unsigned        run_left = 0;

  int          sent_random;
  int          burst;
  int          guard;
  int unsigned pick;
  idle_mode_e  mode;

  always #5 clk_i = ~clk_i;

  fisher_yates_shuffle_engine #(
    .MAX_COUNT(MAX_COUNT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .random_word_i(random_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .position_o   (position_o),
    .value_o      (value_o),
    .last_o       (last_o)
  );

  fys_perm_checker #(
    .MAX_COUNT(MAX_COUNT)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .random_word_i(random_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .position_i   (position_o),
    .value_i      (value_o),
    .last_i       (last_o),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  task automatic set_idling(input idle_mode_e m);
    case (m)
      IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SEND: begin send_pct = 49; recv_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct = 49; end
      default:   begin send_pct = 30; recv_pct = 30; end
    endcase
  endtask

  // offer one random word and hold it until accepted
  task automatic send_word(input logic [WORD_W-1:0] w);
    int gap;
    int unsigned n;
    gap = 0;
    while ($urandom_range(0, 99) < send_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    random_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    // track run boundaries, size saturates into 1..MAX_COUNT
    if (run_left == 0) begin
      n = count_shadow;
      if (n == 0) n = 1;
      if (n > MAX_COUNT) n = MAX_COUNT;
      run_left = n - 1;
    end
    if (run_left > 0) run_left--;
  endtask

  function automatic logic [WORD_W-1:0] any_word();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return WORD_ONES;
    return WORD_W'($urandom);
  endfunction

  // stop offering and wait until every predicted item has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    count_shadow = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    set_idling(IDLE_NONE);

    // ---- directed corners ----
    // count of one: immediate single item, word ignored
    write_count(COUNT_W'(1));
    send_word('0);
    wait_drained();
    // count of zero behaves as one
    write_count('0);
    send_word(WORD_ONES);
    wait_drained();
    // two elements: swap with itself, then a real swap
    write_count(COUNT_W'(2));
    send_word(WORD_ONES);
    send_word('0);
    wait_drained();
    // count changed in the middle of a run only applies to the next run
    write_count(COUNT_W'(3));
    send_word(WORD_W'(32'h1234_5679));
    wait_drained();
    write_count(COUNT_W'(1));
    send_word(WORD_ONES);
    send_word(WORD_W'(7));
    wait_drained();
    write_count(COUNT_W'(4));
    send_word('0);
    send_word('0);
    send_word('0);
    wait_drained();
    write_count(COUNT_W'(5));
    send_word(WORD_ONES);
    send_word(WORD_W'(32'h4000_0000));
    send_word(WORD_W'(32'h5555_5555));
    send_word(WORD_W'(32'h2AAA_AAAA));
    wait_drained();
    write_count(COUNT_W'(6));
    repeat (5) send_word(any_word());

    // ---- random runs, mostly small sizes ----
    sent_random = 0;
    for (int ph = 0; sent_random < 650; ph++) begin
      wait_drained();
      mode = idle_mode_e'(ph % 4);
      set_idling(mode);
      if ($urandom_range(0, 9) < 7) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)      write_count(COUNT_W'($urandom_range(2, 12)));
        else if (pick < 75) write_count(COUNT_W'($urandom_range(13, 64)));
        else if (pick < 88) write_count(COUNT_W'($urandom_range(0, 1)));
        else                write_count(COUNT_W'($urandom_range(65, 200)));
      end
      burst = $urandom_range(20, 60);
      if (ph == 5) begin
        // long output hold-off while words keep coming, backs up the input
        set_idling(IDLE_NONE);
        @(posedge clk_i);
        hold_request = 400;
        burst = 30;
      end
      repeat (burst) send_word(any_word());
      sent_random += burst;
    end

    // ---- largest size: saturated count, top positions of a run ----
    wait_drained();
    set_idling(IDLE_BOTH);
    write_count('1);
    // close whatever run is still open under the old size
    while (run_left != 0) send_word(any_word());
    for (int k = 0; k < 100; k++) begin
      if (k % 25 == 0) set_idling(idle_mode_e'((k / 25) % 4));
      send_word(any_word());
    end

    // ---- drain and verdict ----
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (80) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
